[hdl/etfi_pkg.sv]
// etfi_pkg: widths, fixed-point limits, codes and shared types of the escape-time iterator
// used by etfi_front, etfi_queue, etfi_core and escape_time_fractal_iterator
// no dependencies
`default_nettype none

package etfi_pkg;

    // coordinate format: two's complement, FRAC fraction bits (Q4.28 at 32 bits)
    localparam int COORD_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int FRAC        = COORD_WIDTH - 4;

    // z parts are held clamped to [-2, +2]
    localparam int ZW   = FRAC + 3;
    // magnitude of a part that has not escaped, below 2
    localparam int MAGW = FRAC + 1;
    // exact square of such a magnitude
    localparam int SQW  = 2 * MAGW;
    // new part before clamping
    localparam int SUMW = COORD_WIDTH + 1;

    localparam int CFG_DATA_WIDTH = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH;

    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic signed [ZW-1:0]   Z_LIM  = {2'b01, {(FRAC + 1){1'b0}}};
    localparam logic signed [ZW-1:0]   Z_NLIM = {2'b11, {(FRAC + 1){1'b0}}};
    localparam logic signed [SUMW-1:0] S_LIM  = {{(SUMW - ZW){1'b0}}, Z_LIM};
    localparam logic signed [SUMW-1:0] S_NLIM = {{(SUMW - ZW){1'b1}}, Z_NLIM};

    localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(256);

    typedef enum logic [1:0] {
        MODE_MANDEL = 2'd0,
        MODE_JULIA  = 2'd1,
        MODE_SHIP   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_JREAL = 2'd2,
        CFG_JIMAG = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_CHECK,
        CORE_UPDATE
    } core_state_t;

    // one classified point waiting for the iteration engine
    typedef struct packed {
        logic signed [ZW-1:0]          zr;
        logic signed [ZW-1:0]          zi;
        logic signed [COORD_WIDTH-1:0] cr;
        logic signed [COORD_WIDTH-1:0] ci;
        logic                          ship;
        logic                          skip;
    } q_entry_t;

    // saturate a part of z to [-2, +2]
    function automatic logic signed [ZW-1:0] clamp_z(input logic signed [SUMW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > S_LIM) begin
            r = Z_LIM;
        end else if (v < S_NLIM) begin
            r = Z_NLIM;
        end else begin
            r = v[ZW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/etfi_front.sv]
// etfi_front: accepts points and turns them into start values for the iteration engine
// depends on etfi_pkg
`default_nettype none

module etfi_front (
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   s_point_real,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   s_point_imag,
    input  etfi_pkg::mode_t                           mode,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   julia_real,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   julia_imag,
    input  logic                                      q_full,
    output logic                                      q_push,
    output etfi_pkg::q_entry_t                        q_data
);
    import etfi_pkg::*;

    logic signed [SUMW-1:0] pr_ext;
    logic signed [SUMW-1:0] pi_ext;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign pr_ext = {{(SUMW - COORD_WIDTH){s_point_real[COORD_WIDTH-1]}}, s_point_real};
    assign pi_ext = {{(SUMW - COORD_WIDTH){s_point_imag[COORD_WIDTH-1]}}, s_point_imag};

    always_comb begin
        q_data.ship = (mode == MODE_SHIP);
        q_data.skip = (mode == MODE_NONE);
        case (mode)
            MODE_JULIA: begin
                // start from the point, clamped like every later z
                q_data.zr = clamp_z(pr_ext);
                q_data.zi = clamp_z(pi_ext);
                q_data.cr = julia_real;
                q_data.ci = julia_imag;
            end
            default: begin
                q_data.zr = '0;
                q_data.zi = '0;
                q_data.cr = s_point_real;
                q_data.ci = s_point_imag;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/etfi_queue.sv]
// etfi_queue: short fifo of classified points between front and iteration engine
// depends on etfi_pkg
`default_nettype none

module etfi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  etfi_pkg::q_entry_t  push_data,
    output logic                full,
    input  logic                pop,
    output etfi_pkg::q_entry_t  pop_data,
    output logic                not_empty
);
    import etfi_pkg::*;

    q_entry_t          entries_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QAW-1:0]    rd_ptr_next;
    logic [QAW:0]      level_reg;
    logic [QAW:0]      level_next;

    assign full      = (level_reg == (QAW + 1)'(QDEPTH));
    assign not_empty = (level_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/etfi_core.sv]
// etfi_core: iteration engine, squares z in its check state and updates it in its update state
// depends on etfi_pkg
`default_nettype none

module etfi_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [etfi_pkg::COUNT_WIDTH-1:0]    limit,
    input  logic                                q_valid,
    input  etfi_pkg::q_entry_t                  q_data,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [etfi_pkg::COUNT_WIDTH-1:0]    m_iteration_count
);
    import etfi_pkg::*;

    core_state_t                    state_reg, state_next;
    logic signed [ZW-1:0]           zr_reg, zr_next;
    logic signed [ZW-1:0]           zi_reg, zi_next;
    logic signed [COORD_WIDTH-1:0]  cr_reg, cr_next;
    logic signed [COORD_WIDTH-1:0]  ci_reg, ci_next;
    logic                           ship_reg, ship_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic [SQW-1:0]                 sq_r_reg, sq_r_next;
    logic [SQW-1:0]                 sq_i_reg, sq_i_next;
    logic [SQW-1:0]                 xp_reg, xp_next;
    logic                           neg_reg, neg_next;
    logic                           out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0]         out_count_reg, out_count_next;

    logic signed [ZW-1:0]   zr_abs;
    logic signed [ZW-1:0]   zi_abs;
    logic [MAGW-1:0]        ar;
    logic [MAGW-1:0]        ai;
    logic                   big;
    logic [SQW:0]           mag_sum;
    logic signed [SQW:0]    diff;
    logic signed [SQW:0]    diff_sh;
    logic signed [SQW:0]    prod_s;
    logic signed [SQW:0]    prod_sh;
    logic signed [SUMW-1:0] nr;
    logic signed [SUMW-1:0] ni;
    logic signed [SUMW-1:0] cr_ext;
    logic signed [SUMW-1:0] ci_ext;

    assign m_valid           = out_valid_reg;
    assign m_iteration_count = out_count_reg;

    // magnitudes are only used once a part is known to be below 2
    assign zr_abs = zr_reg[ZW-1] ? -zr_reg : zr_reg;
    assign zi_abs = zi_reg[ZW-1] ? -zi_reg : zi_reg;
    assign ar     = zr_abs[MAGW-1:0];
    assign ai     = zi_abs[MAGW-1:0];
    assign big    = (zr_reg >= Z_LIM) || (zr_reg <= Z_NLIM)
                 || (zi_reg >= Z_LIM) || (zi_reg <= Z_NLIM);

    // |z|^2 >= 4 exactly when the sum carries into bit SQW
    assign mag_sum = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
    assign diff    = $signed({1'b0, sq_r_reg}) - $signed({1'b0, sq_i_reg});
    assign diff_sh = diff >>> FRAC;
    assign prod_s  = neg_reg ? -$signed({1'b0, xp_reg}) : $signed({1'b0, xp_reg});
    assign prod_sh = prod_s >>> (FRAC - 1);
    assign nr      = diff_sh[SUMW-1:0];
    assign ni      = prod_sh[SUMW-1:0];
    assign cr_ext  = {{(SUMW - COORD_WIDTH){cr_reg[COORD_WIDTH-1]}}, cr_reg};
    assign ci_ext  = {{(SUMW - COORD_WIDTH){ci_reg[COORD_WIDTH-1]}}, ci_reg};

    always_comb begin
        state_next     = state_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        ship_next      = ship_reg;
        count_next     = count_reg;
        sq_r_next      = sq_r_reg;
        sq_i_next      = sq_i_reg;
        xp_next        = xp_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            CORE_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop      = 1'b1;
                    zr_next    = q_data.zr;
                    zi_next    = q_data.zi;
                    cr_next    = q_data.cr;
                    ci_next    = q_data.ci;
                    ship_next  = q_data.ship;
                    count_next = '0;
                    if (q_data.skip) begin
                        out_valid_next = 1'b1;
                        out_count_next = '0;
                    end else begin
                        state_next = CORE_CHECK;
                    end
                end
            end
            CORE_CHECK: begin
                if ((count_reg >= limit) || big) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = CORE_IDLE;
                end else begin
                    sq_r_next  = ar * ar;
                    sq_i_next  = ai * ai;
                    xp_next    = ar * ai;
                    neg_next   = !ship_reg && (zr_reg[ZW-1] != zi_reg[ZW-1]);
                    state_next = CORE_UPDATE;
                end
            end
            CORE_UPDATE: begin
                if (mag_sum[SQW]) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = CORE_IDLE;
                end else begin
                    zr_next    = clamp_z(nr + cr_ext);
                    zi_next    = clamp_z(ni + ci_ext);
                    count_next = count_reg + 1'b1;
                    state_next = CORE_CHECK;
                end
            end
            default: begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CORE_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        ship_reg      <= ship_next;
        count_reg     <= count_next;
        sq_r_reg      <= sq_r_next;
        sq_i_reg      <= sq_i_next;
        xp_reg        <= xp_next;
        neg_reg       <= neg_next;
        out_count_reg <= out_count_next;
    end

endmodule

`default_nettype wire

[hdl/escape_time_fractal_iterator.sv]
// escape_time_fractal_iterator: top level, configuration registers, front, queue and engine
// depends on etfi_pkg, etfi_front, etfi_queue, etfi_core
`default_nettype none

// Escape-time iterator for Mandelbrot, Julia and Burning Ship sets. Each input transfer
// carries one Q4.28 point; each output transfer returns the number of iterations of
// z = z^2 + c done before |z|^2 >= 4 or before iteration_limit is reached. The front
// classifies a point (start z, constant c, mode) and parks it in a two-entry queue, so
// new points are taken while the engine is busy and while a result waits at the output.
// The engine squares z with three 29x29 multipliers in its check state and forms the new
// z in its update state, so each iteration passes through both states; the default limit
// is 256. Mode 3 points skip the iteration and return 0, and a zero limit ends a point at
// its first check. Configuration is written through cfg_wr_en, cfg_index and cfg_wdata
// and must only change while no point is in flight.

module escape_time_fractal_iterator (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration write port
    input  logic                                      cfg_wr_en,
    input  etfi_pkg::cfg_idx_t                        cfg_index,
    input  logic [etfi_pkg::CFG_DATA_WIDTH-1:0]       cfg_wdata,
    // point input
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   s_point_real,
    input  logic signed [etfi_pkg::COORD_WIDTH-1:0]   s_point_imag,
    // count output
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [etfi_pkg::COUNT_WIDTH-1:0]          m_iteration_count
);
    import etfi_pkg::*;

    // configuration registers
    mode_t                          mode_reg;
    logic [COUNT_WIDTH-1:0]         limit_reg;
    logic signed [COORD_WIDTH-1:0]  julia_real_reg;
    logic signed [COORD_WIDTH-1:0]  julia_imag_reg;

    // front to queue
    logic       q_push;
    q_entry_t   q_push_data;
    logic       q_full;
    // queue to engine
    logic       q_pop;
    q_entry_t   q_pop_data;
    logic       q_not_empty;

    // register writes, each truncated to the register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_MANDEL;
            limit_reg      <= LIMIT_RESET;
            julia_real_reg <= '0;
            julia_imag_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:  mode_reg       <= mode_t'(cfg_wdata[1:0]);
                CFG_LIMIT: limit_reg      <= cfg_wdata[COUNT_WIDTH-1:0];
                CFG_JREAL: julia_real_reg <= cfg_wdata[COORD_WIDTH-1:0];
                CFG_JIMAG: julia_imag_reg <= cfg_wdata[COORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // classify the point and pick start z and c
    etfi_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_real (s_point_real),
        .s_point_imag (s_point_imag),
        .mode         (mode_reg),
        .julia_real   (julia_real_reg),
        .julia_imag   (julia_imag_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    // decouples input transfers from the iteration loop
    etfi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // iterate and hold the count in the output register
    etfi_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .limit             (limit_reg),
        .q_valid           (q_not_empty),
        .q_data            (q_pop_data),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count)
    );

`ifndef SYNTHESIS
    // a count never passes the configured limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_iteration_count <= limit_reg))
        else $error("iteration count above limit");

    // the engine only takes a point while the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !m_valid)
        else $error("point taken while a result is pending");

    // a pop always finds an entry in the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");

    // a pushed point is visible to the engine in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> q_not_empty)
        else $error("queue empty after push");
`endif

endmodule

`default_nettype wire
